/* design/assert_macros.svh */
// Assertion macros used by the noise block checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define VNF_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("vnf check failed");

// Next-cycle implication, off during reset
`define VNF_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("vnf check failed");

// Next-cycle implication that also watches reset itself
`define VNF_ASSERT_RESET(label, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("vnf check failed");

`endif

/* design/vnf_pkg.sv */
// Shared types, constants and helper functions of the fractal value noise block.
// No dependencies; used by vnf_octave, vnf_div and the top level.
package vnf_pkg;

  localparam int MAX_OCTAVES   = 8;
  localparam int FRACTION_BITS = 16;

  localparam int CNT_W    = 4;
  localparam int AMP_W    = 17;
  localparam int CORNER_W = 24;
  localparam int NOISE_W  = CORNER_W + 2;
  localparam int PROD_W   = NOISE_W + AMP_W;
  localparam int OCT_W    = $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W    = PROD_W + OCT_W;
  localparam int WGT_W    = AMP_W + OCT_W;
  localparam int DEN_W    = WGT_W + CORNER_W;
  localparam int QUO_W    = 16;

  // hash multipliers
  localparam logic [31:0] HASH_X    = 32'h9e3779b9;
  localparam logic [31:0] HASH_Y    = 32'h85ebca6b;
  localparam logic [31:0] HASH_SEED = 32'hc2b2ae35;
  localparam logic [31:0] AVAL_MUL1 = 32'h7feb352d;
  localparam logic [31:0] AVAL_MUL2 = 32'h846ca68b;

  // per-octave steps
  localparam logic [17:0] FREQ_MUL  = 18'd131727;
  localparam logic [31:0] SEED_STEP = 32'd313;
  localparam logic [31:0] SALT_STEP = 32'd3571;

  localparam logic [CORNER_W-1:0]    CORNER_FULL = 24'hffffff;
  localparam logic [AMP_W-1:0]       AMP_ONE     = AMP_W'(65536);
  localparam logic [FRACTION_BITS:0] FRAC_ONE    = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BASE_FREQ = 3'd0,
    REG_OCT_COUNT = 3'd1,
    REG_ROUGHNESS = 3'd2,
    REG_SEED      = 3'd3,
    REG_SALT      = 3'd4
  } vnf_reg_t;

  // one sample in flight between octave units
  typedef struct packed {
    logic signed [31:0]       px;
    logic signed [31:0]       py;
    logic [31:0]              freq;
    logic [31:0]              seed;
    logic [31:0]              salt;
    logic [AMP_W-1:0]         amp;
    logic [OCT_W-1:0]         left;
    logic signed [SUM_W-1:0]  sum;
    logic [WGT_W-1:0]         weight;
  } vnf_item_t;

  // first avalanche round: xor-shift then multiply
  function automatic logic [31:0] vnf_mix1(input logic [31:0] v);
    logic [31:0] x;
    x = v ^ (v >> 16);
    return 32'(x * AVAL_MUL1);
  endfunction

  // second avalanche round
  function automatic logic [31:0] vnf_mix2(input logic [31:0] v);
    logic [31:0] x;
    x = v ^ (v >> 15);
    return 32'(x * AVAL_MUL2);
  endfunction

  // last xor-shift and 24-bit corner mask
  function automatic logic [CORNER_W-1:0] vnf_corner(input logic [31:0] v);
    logic [31:0] x;
    x = v ^ (v >> 16);
    return x[CORNER_W-1:0];
  endfunction

  // linear blend a*(1-s) + b*s, truncated
  function automatic logic [CORNER_W-1:0] vnf_blend(input logic [CORNER_W-1:0] a,
                                                    input logic [CORNER_W-1:0] b,
                                                    input logic [FRACTION_BITS:0] s);
    logic [FRACTION_BITS:0]                  one_s;
    logic [CORNER_W+FRACTION_BITS+1:0]       acc;
    one_s = FRAC_ONE - s;
    acc = (CORNER_W + FRACTION_BITS + 2)'(a) * (CORNER_W + FRACTION_BITS + 2)'(one_s)
        + (CORNER_W + FRACTION_BITS + 2)'(b) * (CORNER_W + FRACTION_BITS + 2)'(s);
    return acc[CORNER_W+FRACTION_BITS-1:FRACTION_BITS];
  endfunction

endpackage

/* design/vnf_octave.sv */
// One octave of value noise as an eight-stage pipeline: scale, lattice hash,
// fade, bilinear blend, weighting and accumulation. Depends on vnf_pkg.
module vnf_octave (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [15:0]        roughness,
  input  logic               in_valid,
  input  vnf_pkg::vnf_item_t in_item,
  output logic               out_valid,
  output vnf_pkg::vnf_item_t out_item
);
  import vnf_pkg::*;

  localparam int FB = FRACTION_BITS;
  localparam logic [FB+1:0] FADE3 = (FB + 2)'(3) << FB;

  // valid bits of stages A..G
  logic [6:0] vld;

  vnf_item_t a_it, b_it, c_it, d_it, e_it, f_it, g_it;
  vnf_item_t b_it_next, out_next;

  // stage A: position scaling and step products
  logic signed [64:0] px_full, py_full;
  logic [63:0]        a_px, a_py;
  logic [31:0]        a_sh;
  logic [49:0]        a_nf;
  logic [32:0]        a_na;

  assign px_full = 65'(in_item.px) * 65'($signed({1'b0, in_item.freq}));
  assign py_full = 65'(in_item.py) * 65'($signed({1'b0, in_item.freq}));

  always_ff @(posedge clk) begin
    if (adv) begin
      a_it <= in_item;
      a_px <= px_full[63:0];
      a_py <= py_full[63:0];
      a_sh <= 32'(in_item.seed * HASH_SEED);
      a_nf <= 50'(in_item.freq) * 50'(FREQ_MUL);
      a_na <= 33'(in_item.amp) * 33'(roughness);
    end
  end

  // stage B: lattice coordinate products and fraction squares
  logic [31:0]     cx, cy;
  logic [FB-1:0]   fx, fy;
  logic [31:0]     b_cx0, b_cx1, b_cy0, b_cy1, b_sk;
  logic [2*FB-1:0] b_ffx, b_ffy;
  logic [FB-1:0]   b_fx, b_fy;
  logic [AMP_W-1:0] b_na;

  assign cx = a_px[63:32];
  assign cy = a_py[63:32];
  assign fx = a_px[31 -: FB];
  assign fy = a_py[31 -: FB];

  always_comb begin
    b_it_next = a_it;
    b_it_next.freq = (a_nf[49:48] != 2'b00) ? 32'hffffffff : a_nf[47:16];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_it  <= b_it_next;
      b_cx0 <= 32'(cx * HASH_X);
      b_cx1 <= 32'((cx + 32'd1) * HASH_X);
      b_cy0 <= 32'(cy * HASH_Y);
      b_cy1 <= 32'((cy + 32'd1) * HASH_Y);
      b_sk  <= a_sh ^ a_it.salt;
      b_ffx <= (2 * FB)'(fx) * (2 * FB)'(fx);
      b_ffy <= (2 * FB)'(fy) * (2 * FB)'(fy);
      b_fx  <= fx;
      b_fy  <= fy;
      b_na  <= a_na[32:16];
    end
  end

  // stage C: corner hashes, first avalanche round, fade product
  logic [31:0]     h00, h10, h01, h11;
  logic [31:0]     c_h00, c_h10, c_h01, c_h11;
  logic [2*FB+1:0] c_tx, c_ty;
  logic [AMP_W-1:0] c_na;

  assign h00 = b_cx0 ^ b_cy0 ^ b_sk;
  assign h10 = b_cx1 ^ b_cy0 ^ b_sk;
  assign h01 = b_cx0 ^ b_cy1 ^ b_sk;
  assign h11 = b_cx1 ^ b_cy1 ^ b_sk;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_it  <= b_it;
      c_h00 <= vnf_mix1(h00);
      c_h10 <= vnf_mix1(h10);
      c_h01 <= vnf_mix1(h01);
      c_h11 <= vnf_mix1(h11);
      c_tx  <= (2 * FB + 2)'(b_ffx[2*FB-1:FB]) * (2 * FB + 2)'(FADE3 - (FB + 2)'({b_fx, 1'b0}));
      c_ty  <= (2 * FB + 2)'(b_ffy[2*FB-1:FB]) * (2 * FB + 2)'(FADE3 - (FB + 2)'({b_fy, 1'b0}));
      c_na  <= b_na;
    end
  end

  // stage D: second avalanche round, fade weights
  logic [31:0]      d_h00, d_h10, d_h01, d_h11;
  logic [FB:0]      d_sx, d_sy;
  logic [AMP_W-1:0] d_na;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_it  <= c_it;
      d_h00 <= vnf_mix2(c_h00);
      d_h10 <= vnf_mix2(c_h10);
      d_h01 <= vnf_mix2(c_h01);
      d_h11 <= vnf_mix2(c_h11);
      d_sx  <= c_tx[2*FB:FB];
      d_sy  <= c_ty[2*FB:FB];
      d_na  <= c_na;
    end
  end

  // stage E: blend along x on both rows
  logic [CORNER_W-1:0] e_ra, e_rb;
  logic [FB:0]         e_sy;
  logic [AMP_W-1:0]    e_na;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_it <= d_it;
      e_ra <= vnf_blend(vnf_corner(d_h00), vnf_corner(d_h10), d_sx);
      e_rb <= vnf_blend(vnf_corner(d_h01), vnf_corner(d_h11), d_sx);
      e_sy <= d_sy;
      e_na <= d_na;
    end
  end

  // stage F: blend along y
  logic [CORNER_W-1:0] f_v;
  logic [AMP_W-1:0]    f_na;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_it <= e_it;
      f_v  <= vnf_blend(e_ra, e_rb, e_sy);
      f_na <= e_na;
    end
  end

  // stage G: remap to signed noise and weight by amplitude
  logic signed [NOISE_W-1:0] n_val;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  g_p;
  logic [AMP_W-1:0]          g_na;

  assign n_val = $signed({1'b0, f_v, 1'b0}) - $signed(NOISE_W'(CORNER_FULL));
  assign prod  = PROD_W'(n_val) * PROD_W'($signed({1'b0, f_it.amp}));

  always_ff @(posedge clk) begin
    if (adv) begin
      g_it <= f_it;
      g_p  <= prod;
      g_na <= f_na;
    end
  end

  // stage H: accumulate and step to the next octave
  logic en;
  assign en = (g_it.left != '0);

  always_comb begin
    out_next = g_it;
    out_next.amp  = g_na;
    out_next.seed = g_it.seed + SEED_STEP;
    out_next.salt = g_it.salt + SALT_STEP;
    if (en) begin
      out_next.sum    = g_it.sum + SUM_W'(g_p);
      out_next.weight = g_it.weight + WGT_W'(g_it.amp);
      out_next.left   = g_it.left - OCT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= out_next;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[5:0], in_valid};
      out_valid <= vld[6];
    end
  end

endmodule

/* design/vnf_div.sv */
// Pipelined signed division of the weighted sum by the total weight, one
// quotient bit per stage, with saturation to Q1.15. Depends on vnf_pkg.
module vnf_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [vnf_pkg::SUM_W-1:0]  sum,
  input  logic [vnf_pkg::WGT_W-1:0]         weight,
  output logic                              out_valid,
  output logic signed [15:0]                noise
);
  import vnf_pkg::*;

  logic [DEN_W:0]   rem  [0:QUO_W];
  logic [DEN_W-1:0] den  [0:QUO_W];
  logic [QUO_W-1:0] quo  [0:QUO_W];
  logic             neg  [0:QUO_W];
  logic             zero [0:QUO_W];
  logic [QUO_W:0]   vld;

  // prep stage: magnitude, sign and denominator weight * (2^24 - 1)
  logic [SUM_W-1:0] mag_full;
  assign mag_full = sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= {1'b0, mag_full[DEN_W-1:0]};
      den[0]  <= (DEN_W'(weight) << CORNER_W) - DEN_W'(weight);
      quo[0]  <= '0;
      neg[0]  <= sum[SUM_W-1];
      zero[0] <= (weight == '0);
    end
  end

  // one restoring step per stage, quotient MSB first
  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    logic         bit_q;
    logic [DEN_W:0] r_sub;
    assign bit_q = (rem[s] >= {1'b0, den[s]});
    assign r_sub = bit_q ? (rem[s] - {1'b0, den[s]}) : rem[s];

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1]  <= {r_sub[DEN_W-1:0], 1'b0};
        den[s+1]  <= den[s];
        quo[s+1]  <= {quo[s][QUO_W-2:0], bit_q};
        neg[s+1]  <= neg[s];
        zero[s+1] <= zero[s];
      end
    end
  end

  // sign, saturation and output register
  logic [QUO_W-1:0] qm;
  assign qm = quo[QUO_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zero[QUO_W]) begin
        noise <= '0;
      end else if (neg[QUO_W]) begin
        noise <= $signed(-qm);
      end else if (qm[QUO_W-1]) begin
        noise <= 16'sh7fff;
      end else begin
        noise <= $signed(qm);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[QUO_W-1:0], in_valid};
      out_valid <= vld[QUO_W];
    end
  end

endmodule

/* design/value_noise_fbm_2d_top.sv */
// Fractal 2-D value noise: one sample position in, one Q1.15 noise word out.
// The block is fully pipelined and takes a new sample every clock cycle unless stalled.
// It holds eight stages in each of the eight octave units (64), then one prep stage,
// sixteen divider stages at one quotient bit each, and the output register.
// Every octave has its own hardware, so octave_count does not change rate or latency;
// octaves beyond the count pass through unused. When noise_stall holds an output word,
// the whole pipeline freezes and sample_stall rises. Configuration must be written
// only while no sample is in flight. Depends on vnf_pkg, vnf_octave and vnf_div.
module value_noise_fbm_2d_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  output logic               noise_valid,
  input  logic               noise_stall,
  output logic signed [15:0] noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import vnf_pkg::*;

  // configuration registers
  logic [31:0]       base_frequency;
  logic [CNT_W-1:0]  octave_count;
  logic [15:0]       roughness;
  logic [31:0]       noise_seed;
  logic [31:0]       hash_salt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frequency <= 32'd65536;
      octave_count   <= CNT_W'(4);
      roughness      <= 16'd36045;
      noise_seed     <= 32'd1337;
      hash_salt      <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_FREQ: base_frequency <= cfg_data;
        REG_OCT_COUNT: octave_count   <= cfg_data[CNT_W-1:0];
        REG_ROUGHNESS: roughness      <= cfg_data[15:0];
        REG_SEED:      noise_seed     <= cfg_data;
        REG_SALT:      hash_salt      <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished word is held
  logic adv;
  assign adv          = !(noise_valid && noise_stall);
  assign sample_stall = !adv;

  // entry word with the octave count clamped
  vnf_item_t entry;
  always_comb begin
    entry.px     = pos_x;
    entry.py     = pos_y;
    entry.freq   = base_frequency;
    entry.seed   = noise_seed;
    entry.salt   = hash_salt;
    entry.amp    = AMP_ONE;
    entry.left   = (octave_count > CNT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                        : OCT_W'(octave_count);
    entry.sum    = '0;
    entry.weight = '0;
  end

  // octave chain
  vnf_item_t chain     [0:MAX_OCTAVES];
  logic      chain_vld [0:MAX_OCTAVES];

  assign chain[0]     = entry;
  assign chain_vld[0] = sample_valid;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    vnf_octave u_oct (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .roughness (roughness),
      .in_valid  (chain_vld[k]),
      .in_item   (chain[k]),
      .out_valid (chain_vld[k+1]),
      .out_item  (chain[k+1])
    );
  end

  // normalization and output register
  vnf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (chain_vld[MAX_OCTAVES]),
    .sum       (chain[MAX_OCTAVES].sum),
    .weight    (chain[MAX_OCTAVES].weight),
    .out_valid (noise_valid),
    .noise     (noise_value)
  );

endmodule

/* design/vnf_checker.sv */
// Port-level checks of the fractal noise block, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module vnf_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic               noise_valid,
  input logic               noise_stall,
  input logic signed [15:0] noise_value
);

  // a held output word stays valid and unchanged
  `VNF_ASSERT_NEXT(a_out_hold, noise_valid && noise_stall, noise_valid && $stable(noise_value))

  // a stalled input keeps sample_valid high on the next cycle
  `VNF_ASSERT_NEXT(a_in_hold, sample_valid && sample_stall, sample_valid)

  // input back-pressure comes only from a held output word
  `VNF_ASSERT_NOW(a_stall_cause, sample_stall, noise_valid && noise_stall)

  // reset empties the pipeline
  `VNF_ASSERT_RESET(a_reset_empty, rst, !noise_valid)

endmodule

bind value_noise_fbm_2d_top vnf_checker u_vnf_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .noise_valid  (noise_valid),
  .noise_stall  (noise_stall),
  .noise_value  (noise_value)
);
